@@ src/smstat_pkg.sv @@
// Shared constants, types and helpers for the sample moment statistics block.
// Used by every module under src; depends on nothing.
package smstat_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SUM_W       = SAMPLE_BITS + ADDR_W + 1;

  localparam int MEAN_W = 24;
  localparam int VAR_W  = 38;
  localparam int SD_W   = 24;
  localparam int SKEW_W = 24;
  localparam int KURT_W = 29;
  localparam int STAT_W = 2;

  // deviation magnitude and moment accumulators
  localparam int E_W  = SAMPLE_BITS + 8;
  localparam int E2_W = 2 * E_W;
  localparam int A2_W = E2_W + ADDR_W + 1;
  localparam int A3_W = 3 * E_W + ADDR_W + 1;
  localparam int A4_W = 4 * E_W + ADDR_W + 1;

  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  localparam int DIVD_W    = 80;
  localparam int DIVS_W    = 48;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  localparam int SQ_IN_W  = 64;
  localparam int SQ_OUT_W = SQ_IN_W / 2;
  localparam int SQ_CNT_W = $clog2(SQ_OUT_W);

  localparam int NORM_BITS = 22;
  localparam int T_LIM     = 53;
  localparam int GDIV_SH   = 26;
  localparam int KDIV_SH   = 16;
  localparam int KQ_LIM    = 56;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SHORT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FLAT  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DROP  = 2'd3;

  localparam logic [SKEW_W-1:0] SKEW_SAT = 24'h800000;
  localparam logic [KURT_W-1:0] KURT_MAX = 29'h0FFFFFFF;
  localparam logic signed [57:0] KURT_BIAS = 58'sd196608;
  localparam logic signed [57:0] KURT_TOP  = 58'sd268435455;

  typedef enum logic [4:0] {
    S_LOAD, S_SUM, S_MDIV, S_MRD, S_ME,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
    S_T3, S_NORM, S_VDIV, S_VSQ, S_RSQ, S_DEN, S_GDIV,
    S_NN, S_CQ, S_GCQ, S_MAGDIV, S_UN0, S_UN1, S_UN2, S_AA, S_KDIV, S_OUT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quo;
    logic [DIVS_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [SQ_IN_W-1:0] operand;
  } sq_req_t;

  typedef struct packed {
    logic                done;
    logic [SQ_OUT_W-1:0] root;
  } sq_rsp_t;

  // sign applied to a skewness magnitude; SKEW_SAT marks saturation
  function automatic logic [SKEW_W-1:0] skew_fix(input logic neg,
                                                 input logic [SKEW_W-1:0] mag);
    logic [SKEW_W-1:0] res;
    if (neg) begin
      res = '0 - mag;
    end else if (mag[SKEW_W-1]) begin
      res = {1'b0, {(SKEW_W-1){1'b1}}};
    end else begin
      res = mag;
    end
    return res;
  endfunction

endpackage

@@ src/smstat_mul.sv @@
// Shared registered unsigned multiplier for the statistics sequencer.
// Depends on smstat_pkg.
module smstat_mul (
  input  logic                          clk,
  input  logic [smstat_pkg::MUL_W-1:0]  a,
  input  logic [smstat_pkg::MUL_W-1:0]  b,
  output logic [smstat_pkg::PROD_W-1:0] prod
);
  import smstat_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign prod = prod_r;

endmodule

@@ src/smstat_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by every quotient.
// Depends on smstat_pkg.
module smstat_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  smstat_pkg::div_req_t  req,
  output smstat_pkg::div_rsp_t  rsp
);
  import smstat_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVD_W-1:0]    quo_r, quo_nxt;
  logic [DIVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVS_W-1:0]    dvs_r, dvs_nxt;
  logic [DIVS_W:0]      rem_sh;
  logic [DIVS_W+1:0]    diff;

  assign rem_sh = {rem_r, quo_r[DIVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIVD_W - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (diff[DIVS_W+1]) begin
        rem_nxt = rem_sh[DIVS_W-1:0];
      end else begin
        rem_nxt = diff[DIVS_W-1:0];
      end
      quo_nxt = {quo_r[DIVD_W-2:0], ~diff[DIVS_W+1]};
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

@@ src/smstat_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on smstat_pkg.
module smstat_sqrt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smstat_pkg::sq_req_t  req,
  output smstat_pkg::sq_rsp_t  rsp
);
  import smstat_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [SQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SQ_IN_W-1:0]  opd_r, opd_nxt;
  logic [SQ_OUT_W+2:0] rem_r, rem_nxt;
  logic [SQ_OUT_W-1:0] root_r, root_nxt;
  logic [SQ_OUT_W+2:0] rem_sh;
  logic [SQ_OUT_W+2:0] trial;

  assign rem_sh = {rem_r[SQ_OUT_W:0], opd_r[SQ_IN_W-1:SQ_IN_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    opd_nxt  = opd_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = SQ_CNT_W'(SQ_OUT_W - 1);
      opd_nxt  = req.operand;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      opd_nxt = {opd_r[SQ_IN_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[SQ_OUT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - SQ_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    opd_r  <= opd_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

@@ src/sample_moment_statistics.sv @@
// Top level: sample store, sequencer and moment datapath of the statistics block.
// Depends on smstat_pkg, smstat_mul, smstat_div and smstat_sqrt.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_sample, in_last
//   out_     output     out_valid/out_stall mean, variance, std dev, skew, kurtosis, status
//
// During loading, a sample is accepted on each request while in_stall is low. After the
// last sample, the record is summed, a moment pass forms six shared-multiplier products
// per sample, up to 20 normalising shifts follow, and up to five quotients and three
// roots are computed bit-serially through the shared units.
// in_stall is high from the last sample until the result has been taken.
// Reset is synchronous; the store needs no clearing.
module sample_moment_statistics (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [smstat_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [smstat_pkg::MEAN_W-1:0] out_mean_value,
  output logic [smstat_pkg::VAR_W-1:0]        out_variance,
  output logic [smstat_pkg::SD_W-1:0]         out_std_dev,
  output logic signed [smstat_pkg::SKEW_W-1:0] out_skewness,
  output logic signed [smstat_pkg::KURT_W-1:0] out_kurtosis,
  output logic [smstat_pkg::STAT_W-1:0]       out_status
);
  import smstat_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             issued_r, issued_nxt;
  logic             rdv_r, rdv_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  logic signed [SUM_W-1:0] s1_r, s1_nxt;
  logic [MEAN_W-1:0] mean_r, mean_nxt;
  logic [E_W-1:0]    ue_r, ue_nxt;
  logic              eneg_r, eneg_nxt;
  logic [E2_W-1:0]   e2_r, e2_nxt;
  logic [A2_W-1:0]   a2_r, a2_nxt;
  logic [A3_W-1:0]   p3_r, p3_nxt;
  logic [A3_W-1:0]   n3_r, n3_nxt;
  logic [A4_W-1:0]   a4_r, a4_nxt;
  logic [A2_W-1:0]   a_r, a_nxt;
  logic [A2_W-1:0]   v_r, v_nxt;
  logic              neg_r, neg_nxt;
  logic [SKEW_W-2:0] g_r, g_nxt;
  logic [PROD_W-1:0] w_r, w_nxt;
  logic [PROD_W-1:0] num_r, num_nxt;
  logic [VAR_W-1:0]  var_r, var_nxt;
  logic [SD_W-1:0]   sd_r, sd_nxt;
  logic [SKEW_W-1:0] skew_r, skew_nxt;
  logic [KURT_W-1:0] kurt_r, kurt_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;

  logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic                   rd_en;
  logic                   wr_en;
  logic [ADDR_W-1:0]      rd_addr;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_r;
  div_req_t div_req;
  div_rsp_t div_rsp;
  sq_req_t  sq_req;
  sq_rsp_t  sq_rsp;

  logic              in_acc;
  logic              full;
  logic [CNT_W-1:0]  idx_inc, cnt_m1, cnt_m2;
  logic              div_done, sq_done;
  logic              a_big, t_big, u_big;
  logic [SUM_W-1:0]  s1_abs;
  logic [MEAN_W:0]   mq, mneg;
  logic signed [E_W+1:0] e_val;
  logic [E_W+1:0]    e_abs;
  logic [A3_W-1:0]   t3_pos, t3_neg;
  logic [77:0]       un_full;
  logic signed [57:0] kd;
  logic [SKEW_W-1:0] mag;

  smstat_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod_r));
  smstat_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  smstat_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sq_req), .rsp(sq_rsp));

  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid & ~in_stall;
  assign full     = (cnt_r >= CNT_W'(MAX_SAMPLES));
  assign wr_en    = in_acc & ~full;
  assign idx_inc  = idx_r + CNT_W'(1);
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign cnt_m2   = cnt_r - CNT_W'(2);
  assign div_done = issued_r & div_rsp.done;
  assign sq_done  = issued_r & sq_rsp.done;
  assign a_big    = |a_r[A2_W-1:NORM_BITS];
  assign t_big    = |p3_r[A3_W-1:T_LIM];
  assign u_big    = |a4_r[A4_W-1:PROD_W];
  assign rd_addr  = idx_r[ADDR_W-1:0];

  assign s1_abs = s1_r[SUM_W-1] ? SUM_W'(-s1_r) : SUM_W'(s1_r);
  assign mq     = {1'b0, div_rsp.quo[MEAN_W-1:0]}
                  + (MEAN_W+1)'(s1_r[SUM_W-1] & (div_rsp.rem != '0));
  assign mneg   = '0 - mq;
  assign e_val  = $signed({{2{rd_data_r[SAMPLE_BITS-1]}}, rd_data_r, 8'd0})
                  - $signed({{2{mean_r[MEAN_W-1]}}, mean_r});
  assign e_abs  = e_val[E_W+1] ? (E_W+2)'(-e_val) : (E_W+2)'(e_val);
  assign t3_pos = p3_r - n3_r;
  assign t3_neg = n3_r - p3_r;
  assign un_full = 78'(w_r) + (78'(prod_r) << 32);
  assign kd     = $signed({2'b00, div_rsp.quo[KQ_LIM-1:0]}) - KURT_BIAS;
  assign mag    = (|div_rsp.quo[DIVD_W-1:SKEW_W]
                   || (div_rsp.quo[SKEW_W-1] && |div_rsp.quo[SKEW_W-2:0]))
                  ? SKEW_SAT : div_rsp.quo[SKEW_W-1:0];

  // store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[ADDR_W-1:0]] <= in_sample;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD:   if (in_acc && in_last) state_nxt = S_SUM;
      S_SUM:    if (idx_r >= cnt_r && !rdv_r) state_nxt = S_MDIV;
      S_MDIV:   if (div_done) state_nxt = (cnt_r < CNT_W'(2)) ? S_OUT : S_MRD;
      S_MRD:    state_nxt = S_ME;
      S_ME:     state_nxt = S_P0;
      S_P0:     state_nxt = S_P1;
      S_P1:     state_nxt = S_P2;
      S_P2:     state_nxt = S_P3;
      S_P3:     state_nxt = S_P4;
      S_P4:     state_nxt = S_P5;
      S_P5:     state_nxt = S_P6;
      S_P6:     state_nxt = S_P7;
      S_P7:     state_nxt = (idx_inc < cnt_r) ? S_MRD : S_T3;
      S_T3:     state_nxt = (a2_r == '0) ? S_OUT : S_NORM;
      S_NORM:   if (!a_big) state_nxt = S_VDIV;
      S_VDIV:   if (div_done) state_nxt = S_VSQ;
      S_VSQ:    if (sq_done) state_nxt = (cnt_r > CNT_W'(2)) ? S_RSQ : S_UN0;
      S_RSQ:    if (sq_done) state_nxt = S_DEN;
      S_DEN:    state_nxt = t_big ? S_UN0 : S_GDIV;
      S_GDIV:   if (div_done) state_nxt = (|div_rsp.quo[DIVD_W-1:SKEW_W-1]) ? S_UN0 : S_NN;
      S_NN:     state_nxt = S_CQ;
      S_CQ:     if (sq_done) state_nxt = S_GCQ;
      S_GCQ:    state_nxt = S_MAGDIV;
      S_MAGDIV: if (div_done) state_nxt = S_UN0;
      S_UN0:    state_nxt = u_big ? S_OUT : S_UN1;
      S_UN1:    state_nxt = S_UN2;
      S_UN2:    state_nxt = (|un_full[77:PROD_W]) ? S_OUT : S_AA;
      S_AA:     state_nxt = S_KDIV;
      S_KDIV:   if (div_done) state_nxt = S_OUT;
      S_OUT:    if (!out_stall) state_nxt = S_LOAD;
      default:  state_nxt = S_LOAD;
    endcase
  end

  // unit control
  always_comb begin
    rd_en            = 1'b0;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    sq_req.start     = 1'b0;
    sq_req.operand   = '0;
    case (state_r)
      S_SUM:  rd_en = (idx_r < cnt_r);
      S_MRD:  rd_en = 1'b1;
      S_MDIV: begin
        div_req.start    = ~issued_r;
        div_req.dividend = DIVD_W'({s1_abs, 8'd0});
        div_req.divisor  = DIVS_W'(cnt_r);
      end
      S_P0: begin
        mul_a = MUL_W'(ue_r);
        mul_b = MUL_W'(ue_r);
      end
      S_P2: begin
        mul_a = MUL_W'(e2_r[E_W-1:0]);
        mul_b = MUL_W'(ue_r);
      end
      S_P3: begin
        mul_a = MUL_W'(e2_r[E2_W-1:E_W]);
        mul_b = MUL_W'(ue_r);
      end
      S_P4: begin
        mul_a = MUL_W'(e2_r[E_W-1:0]);
        mul_b = MUL_W'(e2_r[E_W-1:0]);
      end
      S_P5: begin
        mul_a = MUL_W'(e2_r[E_W-1:0]);
        mul_b = MUL_W'(e2_r[E2_W-1:E_W]);
      end
      S_P6: begin
        mul_a = MUL_W'(e2_r[E2_W-1:E_W]);
        mul_b = MUL_W'(e2_r[E2_W-1:E_W]);
      end
      S_VDIV: begin
        div_req.start    = ~issued_r;
        div_req.dividend = DIVD_W'(a2_r);
        div_req.divisor  = DIVS_W'(cnt_m1);
      end
      S_VSQ: begin
        sq_req.start   = ~issued_r;
        sq_req.operand = SQ_IN_W'(v_r);
      end
      S_RSQ: begin
        sq_req.start   = ~issued_r;
        sq_req.operand = SQ_IN_W'({a_r[NORM_BITS-1:0], 20'd0});
      end
      S_DEN: begin
        mul_a = MUL_W'(a_r[NORM_BITS-1:0]);
        mul_b = sq_rsp.root;
      end
      S_GDIV: begin
        div_req.start    = ~issued_r;
        div_req.dividend = DIVD_W'({p3_r[T_LIM-1:0], {GDIV_SH{1'b0}}});
        div_req.divisor  = prod_r[DIVS_W-1:0];
      end
      S_NN: begin
        mul_a = MUL_W'(cnt_r);
        mul_b = MUL_W'(cnt_m1);
      end
      S_CQ: begin
        sq_req.start   = ~issued_r;
        sq_req.operand = SQ_IN_W'({prod_r[2*CNT_W-1:0], 30'd0});
      end
      S_GCQ: begin
        mul_a = MUL_W'(g_r);
        mul_b = sq_rsp.root;
      end
      S_MAGDIV: begin
        div_req.start    = ~issued_r;
        div_req.dividend = DIVD_W'(prod_r);
        div_req.divisor  = DIVS_W'({cnt_m2, 15'd0});
      end
      S_UN0: begin
        mul_a = a4_r[MUL_W-1:0];
        mul_b = MUL_W'(cnt_r);
      end
      S_UN1: begin
        mul_a = a4_r[PROD_W-1:MUL_W];
        mul_b = MUL_W'(cnt_r);
      end
      S_AA: begin
        mul_a = MUL_W'(a_r[NORM_BITS-1:0]);
        mul_b = MUL_W'(a_r[NORM_BITS-1:0]);
      end
      S_KDIV: begin
        div_req.start    = ~issued_r;
        div_req.dividend = {num_r, {KDIV_SH{1'b0}}};
        div_req.divisor  = prod_r[DIVS_W-1:0];
      end
      default: rd_en = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    issued_nxt = issued_r;
    rdv_nxt    = rdv_r;
    idx_nxt    = idx_r;
    s1_nxt     = s1_r;
    mean_nxt   = mean_r;
    ue_nxt     = ue_r;
    eneg_nxt   = eneg_r;
    e2_nxt     = e2_r;
    a2_nxt     = a2_r;
    p3_nxt     = p3_r;
    n3_nxt     = n3_r;
    a4_nxt     = a4_r;
    a_nxt      = a_r;
    v_nxt      = v_r;
    neg_nxt    = neg_r;
    g_nxt      = g_r;
    w_nxt      = w_r;
    num_nxt    = num_r;
    var_nxt    = var_r;
    sd_nxt     = sd_r;
    skew_nxt   = skew_r;
    kurt_nxt   = kurt_r;
    status_nxt = status_r;

    case (state_r)
      S_MDIV, S_VDIV, S_VSQ, S_RSQ, S_GDIV, S_CQ, S_MAGDIV, S_KDIV: begin
        if (!issued_r) begin
          issued_nxt = 1'b1;
        end else if (div_rsp.done || sq_rsp.done) begin
          issued_nxt = 1'b0;
        end
      end
      default: issued_nxt = 1'b0;
    endcase

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (in_last) begin
            idx_nxt = '0;
            s1_nxt  = '0;
            rdv_nxt = 1'b0;
          end
        end
      end
      S_SUM: begin
        if (idx_r < cnt_r) begin
          idx_nxt = idx_inc;
          rdv_nxt = 1'b1;
        end else begin
          rdv_nxt = 1'b0;
        end
        if (rdv_r) begin
          s1_nxt = s1_r + $signed({{(SUM_W-SAMPLE_BITS){rd_data_r[SAMPLE_BITS-1]}},
                                   rd_data_r});
        end
      end
      S_MDIV: begin
        if (div_done) begin
          mean_nxt   = s1_r[SUM_W-1] ? mneg[MEAN_W-1:0] : mq[MEAN_W-1:0];
          var_nxt    = '0;
          sd_nxt     = '0;
          skew_nxt   = '0;
          kurt_nxt   = '0;
          status_nxt = STAT_SHORT;
          idx_nxt    = '0;
          a2_nxt     = '0;
          p3_nxt     = '0;
          n3_nxt     = '0;
          a4_nxt     = '0;
        end
      end
      S_ME: begin
        ue_nxt   = e_abs[E_W-1:0];
        eneg_nxt = e_val[E_W+1];
      end
      S_P1: begin
        e2_nxt = prod_r[E2_W-1:0];
        a2_nxt = a2_r + A2_W'(prod_r[E2_W-1:0]);
      end
      S_P3, S_P4: begin
        if (eneg_r) begin
          n3_nxt = n3_r + ((state_r == S_P4) ? (A3_W'(prod_r) << E_W) : A3_W'(prod_r));
        end else begin
          p3_nxt = p3_r + ((state_r == S_P4) ? (A3_W'(prod_r) << E_W) : A3_W'(prod_r));
        end
      end
      S_P5: a4_nxt = a4_r + A4_W'(prod_r);
      S_P6: a4_nxt = a4_r + (A4_W'(prod_r) << (E_W + 1));
      S_P7: begin
        a4_nxt  = a4_r + (A4_W'(prod_r) << E2_W);
        idx_nxt = idx_inc;
      end
      S_T3: begin
        neg_nxt = (p3_r < n3_r);
        p3_nxt  = (p3_r < n3_r) ? t3_neg : t3_pos;
        a_nxt   = a2_r;
        if (a2_r == '0) begin
          status_nxt = STAT_FLAT;
        end else begin
          status_nxt = ovf_r ? STAT_DROP : STAT_OK;
        end
      end
      S_NORM: begin
        if (a_big) begin
          a_nxt  = a_r >> 2;
          p3_nxt = p3_r >> 3;
          a4_nxt = a4_r >> 4;
        end
      end
      S_VDIV: begin
        if (div_done) begin
          v_nxt = div_rsp.quo[A2_W-1:0];
          if (|div_rsp.quo[A2_W-1:VAR_W+8]) begin
            var_nxt = '1;
          end else begin
            var_nxt = div_rsp.quo[VAR_W+7:8];
          end
        end
      end
      S_VSQ: begin
        if (sq_done) begin
          sd_nxt = (|sq_rsp.root[SQ_OUT_W-1:SD_W]) ? '1 : sq_rsp.root[SD_W-1:0];
        end
      end
      S_DEN: begin
        if (t_big) begin
          skew_nxt = skew_fix(neg_r, SKEW_SAT);
        end
      end
      S_GDIV: begin
        if (div_done) begin
          if (|div_rsp.quo[DIVD_W-1:SKEW_W-1]) begin
            skew_nxt = skew_fix(neg_r, SKEW_SAT);
          end else begin
            g_nxt = div_rsp.quo[SKEW_W-2:0];
          end
        end
      end
      S_MAGDIV: begin
        if (div_done) begin
          skew_nxt = skew_fix(neg_r, mag);
        end
      end
      S_UN0: begin
        if (u_big) begin
          kurt_nxt = KURT_MAX;
        end
      end
      S_UN1: w_nxt = prod_r;
      S_UN2: begin
        if (|un_full[77:PROD_W]) begin
          kurt_nxt = KURT_MAX;
        end else begin
          num_nxt = un_full[PROD_W-1:0];
        end
      end
      S_KDIV: begin
        if (div_done) begin
          if (|div_rsp.quo[DIVD_W-1:KQ_LIM] || kd > KURT_TOP) begin
            kurt_nxt = KURT_MAX;
          end else begin
            kurt_nxt = kd[KURT_W-1:0];
          end
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
      issued_r <= 1'b0;
      rdv_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      issued_r <= issued_nxt;
      rdv_r    <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    s1_r     <= s1_nxt;
    mean_r   <= mean_nxt;
    ue_r     <= ue_nxt;
    eneg_r   <= eneg_nxt;
    e2_r     <= e2_nxt;
    a2_r     <= a2_nxt;
    p3_r     <= p3_nxt;
    n3_r     <= n3_nxt;
    a4_r     <= a4_nxt;
    a_r      <= a_nxt;
    v_r      <= v_nxt;
    neg_r    <= neg_nxt;
    g_r      <= g_nxt;
    w_r      <= w_nxt;
    num_r    <= num_nxt;
    var_r    <= var_nxt;
    sd_r     <= sd_nxt;
    skew_r   <= skew_nxt;
    kurt_r   <= kurt_nxt;
    status_r <= status_nxt;
  end

  assign out_valid      = (state_r == S_OUT);
  assign out_mean_value = mean_r;
  assign out_variance   = var_r;
  assign out_std_dev    = sd_r;
  assign out_skewness   = skew_r;
  assign out_kurtosis   = kurt_r;
  assign out_status     = status_r;

endmodule
